[sv/fps_pkg.sv]
// ----------------------------------------------------------------------------
// fps_pkg
// Shared types and constants for the flow priority scheduler.
// ----------------------------------------------------------------------------
package fps_pkg;

    localparam int unsigned QueueDepthDefault = 128;
    localparam int unsigned TimeWidth         = 16;
    localparam int unsigned IdWidth           = 8;
    localparam int unsigned PrioWidth         = 4;
    localparam int unsigned KeyWidth          = PrioWidth + 2 * TimeWidth + IdWidth;

    typedef enum logic {
        CMD_REQUEST = 1'b0,
        CMD_RELEASE = 1'b1
    } command_t;

    typedef enum logic [1:0] {
        ST_GRANTED = 2'd0,
        ST_QUEUED  = 2'd1,
        ST_DROPPED = 2'd2,
        ST_IDLE    = 2'd3
    } status_t;

    typedef struct packed {
        command_t               command;
        logic [IdWidth-1:0]     flow_id;
        logic [PrioWidth-1:0]   flow_priority;
        logic [TimeWidth-1:0]   arrival_time;
        logic [TimeWidth-1:0]   transmit_time;
    } in_t;

    typedef struct packed {
        status_t                status;
        logic [IdWidth-1:0]     grant_id;
        logic [7:0]             queue_count;
        logic                   pipe_busy;
    } out_t;

endpackage

[sv/fps_entry_ram.sv]
// ----------------------------------------------------------------------------
// fps_entry_ram
// Single-port-write, single-port-read memory with a registered read.
// ----------------------------------------------------------------------------
module fps_entry_ram #(
    parameter int unsigned DEPTH = fps_pkg::QueueDepthDefault,
    parameter int unsigned WIDTH = fps_pkg::KeyWidth
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/flow_priority_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// flow_priority_scheduler_unit
// Every command ends in res_reg, then the output register. Release with N
// flows waiting first does one memory read per cycle to find the most
// urgent entry, then refills its slot with the last one. One item at a time.
// Reset (aresetn low, synchronous) empties the queue and frees the pipe;
// the entry memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module flow_priority_scheduler_unit #(
    parameter int unsigned QUEUE_DEPTH = fps_pkg::QueueDepthDefault
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  fps_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output fps_pkg::out_t m_data
);

    localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned KW = fps_pkg::KeyWidth;
    localparam int unsigned IW = fps_pkg::IdWidth;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIX,
        S_FINISH
    } state_t;

    state_t             state_reg;
    logic [CW-1:0]      count_reg;
    logic               busy_reg;
    logic [CW-1:0]      rd_idx_reg;
    logic               rd_valid_reg;
    logic [AW-1:0]      rd_addr_reg;
    logic [KW-1:0]      best_key_reg;
    logic [AW-1:0]      best_addr_reg;
    logic [KW-1:0]      last_key_reg;
    fps_pkg::out_t      res_reg;
    logic               m_valid_reg;
    fps_pkg::out_t      m_data_reg;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [KW-1:0]      wr_data;
    logic               rd_en;
    logic [KW-1:0]      rd_data;
    logic [KW-1:0]      in_key;
    logic [AW-1:0]      last_addr;
    logic               take_new;
    logic [KW-1:0]      best_key_next;
    logic [AW-1:0]      best_addr_next;
    logic [CW-1:0]      count_dec;
    logic               accept;

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign in_key    = {s_data.flow_priority, s_data.arrival_time,
                        s_data.transmit_time, s_data.flow_id};
    assign count_dec = count_reg - CW'(1);
    assign last_addr = AW'(count_dec);
    assign rd_en     = (state_reg == S_SCAN) && (rd_idx_reg < count_reg);

    assign take_new       = (rd_addr_reg == AW'(0)) || (rd_data < best_key_reg);
    assign best_key_next  = take_new ? rd_data : best_key_reg;
    assign best_addr_next = take_new ? rd_addr_reg : best_addr_reg;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = AW'(count_reg);
        wr_data = in_key;
        if (state_reg == S_FIX) begin
            wr_en   = 1'b1;
            wr_addr = best_addr_reg;
            wr_data = last_key_reg;
        end else if (accept && (s_data.command == fps_pkg::CMD_REQUEST)
                     && !((count_reg == CW'(0)) && !busy_reg)
                     && (count_reg < CW'(QUEUE_DEPTH))) begin
            wr_en = 1'b1;
        end
    end

    fps_entry_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (KW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            busy_reg     <= 1'b0;
            rd_idx_reg   <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            rd_valid_reg <= rd_en;
            if (rd_en) begin
                rd_idx_reg  <= rd_idx_reg + CW'(1);
                rd_addr_reg <= rd_idx_reg[AW-1:0];
            end
            if (m_valid_reg && m_ready && (state_reg != S_FINISH)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        res_reg.grant_id <= '0;
                        state_reg        <= S_FINISH;
                        if (s_data.command == fps_pkg::CMD_REQUEST) begin
                            if ((count_reg == CW'(0)) && !busy_reg) begin
                                busy_reg         <= 1'b1;
                                res_reg.status   <= fps_pkg::ST_GRANTED;
                                res_reg.grant_id <= s_data.flow_id;
                            end else if (count_reg >= CW'(QUEUE_DEPTH)) begin
                                res_reg.status   <= fps_pkg::ST_DROPPED;
                            end else begin
                                count_reg        <= count_reg + CW'(1);
                                res_reg.status   <= fps_pkg::ST_QUEUED;
                            end
                        end else if (count_reg == CW'(0)) begin
                            busy_reg       <= 1'b0;
                            res_reg.status <= fps_pkg::ST_IDLE;
                        end else begin
                            rd_idx_reg <= '0;
                            state_reg  <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (rd_valid_reg) begin
                        best_key_reg  <= best_key_next;
                        best_addr_reg <= best_addr_next;
                        if (rd_addr_reg == last_addr) begin
                            last_key_reg <= rd_data;
                            state_reg    <= S_FIX;
                        end
                    end
                end
                S_FIX: begin
                    count_reg        <= count_dec;
                    busy_reg         <= 1'b1;
                    res_reg.status   <= fps_pkg::ST_GRANTED;
                    res_reg.grant_id <= best_key_reg[IW-1:0];
                    state_reg        <= S_FINISH;
                end
                S_FINISH: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg             <= 1'b1;
                        m_data_reg.status       <= res_reg.status;
                        m_data_reg.grant_id     <= res_reg.grant_id;
                        m_data_reg.queue_count  <= 8'(count_reg);
                        m_data_reg.pipe_busy    <= busy_reg;
                        state_reg               <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[sim/tb_flow_priority_scheduler_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_flow_priority_scheduler_unit
// Drives requests and releases into the scheduler and checks every result
// against a sorted-queue predictor kept in the testbench, under random
// stalls on both channels and with the waiting queue driven to full.
// ----------------------------------------------------------------------------
module tb_flow_priority_scheduler_unit;
    import fps_pkg::*;

    localparam int unsigned Depth      = QueueDepthDefault;
    localparam int unsigned StallLimit = 20000;

    typedef struct packed {
        logic [PrioWidth-1:0] prio;
        logic [TimeWidth-1:0] arrival;
        logic [TimeWidth-1:0] trans;
        logic [IdWidth-1:0]   id;
    } flow_key_t;

    logic  aclk = 1'b0;
    logic  aresetn = 1'b0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    in_t   s_data = '0;
    logic  m_valid;
    logic  m_ready = 1'b0;
    out_t  m_data;

    in_t       pending_items[$];
    out_t      expected_results[$];
    flow_key_t waiting_flows[$];
    logic      pipe_taken;

    int  send_idle_pct = 28;
    int  recv_idle_pct = 75;
    bit  hold_receiver = 1'b0;
    int  hold_cycles = 0;
    int  mismatches = 0;
    int  quiet_cycles = 0;

    flow_priority_scheduler_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic out_t schedule_flow(in_t item);
        out_t      res;
        flow_key_t key;
        int        pos;
        res = '0;
        if (item.command == CMD_REQUEST) begin
            key = '{item.flow_priority, item.arrival_time, item.transmit_time, item.flow_id};
            if (waiting_flows.size() == 0 && !pipe_taken) begin
                pipe_taken = 1'b1;
                res.status = ST_GRANTED;
                res.grant_id = item.flow_id;
            end else if (waiting_flows.size() >= Depth) begin
                res.status = ST_DROPPED;
            end else begin
                pos = waiting_flows.size();
                while (pos > 0 && key < waiting_flows[pos-1]) pos--;
                waiting_flows.insert(pos, key);
                res.status = ST_QUEUED;
            end
        end else if (waiting_flows.size() > 0) begin
            key = waiting_flows.pop_front();
            pipe_taken = 1'b1;
            res.status = ST_GRANTED;
            res.grant_id = key.id;
        end else begin
            pipe_taken = 1'b0;
            res.status = ST_IDLE;
        end
        res.queue_count = 8'(waiting_flows.size());
        res.pipe_busy = pipe_taken;
        return res;
    endfunction

    function automatic in_t make_request(int prio_hi);
        in_t item;
        item.command = CMD_REQUEST;
        item.flow_id = 8'($urandom);
        item.flow_priority = 4'($urandom_range(0, prio_hi));
        item.arrival_time = ($urandom_range(0, 1)) ? 16'($urandom_range(0, 7)) : 16'($urandom);
        item.transmit_time = ($urandom_range(0, 1)) ? 16'($urandom_range(0, 7)) : 16'($urandom);
        return item;
    endfunction

    function automatic in_t make_release();
        in_t item;
        item = in_t'({$urandom, $urandom});
        item.command = CMD_RELEASE;
        return item;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data <= pending_items.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (s_valid && s_ready && aresetn) begin
            expected_results.push_back(schedule_flow(s_data));
        end
    end

    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else if (hold_receiver) begin
            hold_receiver <= 1'b0;
            hold_cycles <= 600;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transfer: %p", m_data);
            end else begin
                out_t exp_res;
                exp_res = expected_results.pop_front();
                if (m_data.status !== exp_res.status || m_data.grant_id !== exp_res.grant_id
                    || m_data.queue_count !== exp_res.queue_count
                    || m_data.pipe_busy !== exp_res.pipe_busy) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", exp_res, m_data);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_items.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
    endtask

    initial begin
        in_t item;
        pipe_taken = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: release while idle, grant, ties, field extremes.
        pending_items.push_back(make_release());
        item = '{CMD_REQUEST, 8'hFF, 4'hF, 16'hFFFF, 16'hFFFF};
        pending_items.push_back(item);
        pending_items.push_back('{CMD_REQUEST, 8'h00, 4'h0, 16'h0000, 16'h0000});
        pending_items.push_back('{CMD_REQUEST, 8'h05, 4'h3, 16'h0010, 16'h0020});
        pending_items.push_back('{CMD_REQUEST, 8'h04, 4'h3, 16'h0010, 16'h0020});
        pending_items.push_back('{CMD_REQUEST, 8'h04, 4'h3, 16'h0010, 16'h0020});
        pending_items.push_back('{CMD_REQUEST, 8'h06, 4'h3, 16'h0010, 16'h001F});
        pending_items.push_back('{CMD_REQUEST, 8'h07, 4'h3, 16'h000F, 16'hFFFF});
        pending_items.push_back('{CMD_REQUEST, 8'hAA, 4'hF, 16'hFFFF, 16'hFFFF});
        pending_items.push_back('{CMD_REQUEST, 8'h55, 4'h0, 16'hFFFF, 16'hFFFF});
        repeat (10) pending_items.push_back(make_release());
        wait_drained();

        // Fill the queue to its depth and beyond so requests are dropped,
        // with the receiver held off long enough for the input to stall.
        @(posedge aclk) hold_receiver <= 1'b1;
        repeat (Depth + 6) pending_items.push_back(make_request(15));
        wait_drained();
        repeat (Depth + 2) pending_items.push_back(make_release());
        wait_drained();

        send_idle_pct = 28;
        recv_idle_pct = 75;
        for (int k = 0; k < 40; k++) begin
            if ($urandom_range(0, 99) < 55) pending_items.push_back(make_request(3));
            else pending_items.push_back(make_release());
        end
        wait_drained();

        send_idle_pct = 75;
        recv_idle_pct = 28;
        for (int k = 0; k < 40; k++) begin
            if ($urandom_range(0, 99) < 60) pending_items.push_back(make_request(15));
            else pending_items.push_back(make_release());
        end
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int k = 0; k < 40; k++) begin
            if ($urandom_range(0, 99) < 50) pending_items.push_back(make_request(1));
            else pending_items.push_back(make_release());
        end
        wait_drained();

        repeat (Depth + 20) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
